// File: hdl/fdhs_pkg.sv
// fdhs_pkg: shared constants and coefficient rom for the decimating fir
`timescale 1ns / 1ps
`default_nettype none
package fdhs_pkg;

  localparam int DECIM_FACTOR   = 4;
  localparam int TAP_COUNT      = 8 * DECIM_FACTOR + 1;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_W         = 16;
  localparam int PROD_W         = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W          = 40;
  localparam int PHASE_W        = (DECIM_FACTOR > 1) ? $clog2(DECIM_FACTOR) : 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]       coef_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic [PHASE_W-1:0]             phase_t;

  // hamming-windowed sinc, cutoff pi/4, dc gain 1, q1.15
  localparam coef_t COEF_ROM [TAP_COUNT] = '{
    16'sd0,     -16'sd44,   -16'sd86,   -16'sd90,   16'sd0,     16'sd191,
    16'sd381,   16'sd370,   16'sd0,     -16'sd665,  -16'sd1248, -16'sd1176,
    16'sd0,     16'sd2273,  16'sd5044,  16'sd7327,  16'sd8211,  16'sd7327,
    16'sd5044,  16'sd2273,  16'sd0,     -16'sd1176, -16'sd1248, -16'sd665,
    16'sd0,     16'sd370,   16'sd381,   16'sd191,   16'sd0,     -16'sd90,
    -16'sd86,   -16'sd44,   16'sd0
  };

endpackage
`default_nettype wire

// File: hdl/fdhs_cell.sv
// fdhs_cell: one transposed-form tap, multiply the sample and add the neighbor sum
`timescale 1ns / 1ps
`default_nettype none
module fdhs_cell #(
  parameter int TAP_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             clear_i,
  input  wire fdhs_pkg::sample_t x_i,
  input  wire fdhs_pkg::acc_t   sum_i,
  output fdhs_pkg::acc_t        sum_o
);

  localparam fdhs_pkg::coef_t Coef = fdhs_pkg::COEF_ROM[TAP_IDX];

  logic signed [fdhs_pkg::PROD_W-1:0] prod;
  fdhs_pkg::acc_t                     neigh;
  fdhs_pkg::acc_t                     sum_d;
  fdhs_pkg::acc_t                     sum_q;

  // tap product plus neighbor partial sum, neighbor dropped on start of signal
  always_comb begin
    prod  = x_i * Coef;
    neigh = clear_i ? '0 : sum_i;
    sum_d = {{(fdhs_pkg::ACC_W - fdhs_pkg::PROD_W){prod[fdhs_pkg::PROD_W-1]}}, prod} + neigh;
  end

  // partial sum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// File: hdl/fdhs_outstage.sv
// fdhs_outstage: round, saturate and hold the decimated output sample
`timescale 1ns / 1ps
`default_nettype none
module fdhs_outstage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire fdhs_pkg::acc_t   acc_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output fdhs_pkg::sample_t     sample_o
);

  localparam int F = fdhs_pkg::COEF_FRAC_BITS;
  localparam int W = fdhs_pkg::SAMPLE_WIDTH;
  localparam fdhs_pkg::acc_t Half   = fdhs_pkg::acc_t'(1) <<< (F - 1);
  localparam fdhs_pkg::acc_t MaxVal = (fdhs_pkg::acc_t'(1) <<< (W - 1)) - fdhs_pkg::acc_t'(1);
  localparam fdhs_pkg::acc_t MinVal = -(fdhs_pkg::acc_t'(1) <<< (W - 1));

  fdhs_pkg::acc_t    biased;
  fdhs_pkg::acc_t    shifted;
  fdhs_pkg::sample_t sat;
  logic              out_valid_q;
  logic              out_valid_d;
  fdhs_pkg::sample_t sample_q;

  // round half up, floor shift, clamp to sample range
  always_comb begin
    biased  = acc_i + Half;
    shifted = biased >>> F;
    if (shifted > MaxVal) begin
      sat = fdhs_pkg::sample_t'(MaxVal);
    end else if (shifted < MinVal) begin
      sat = fdhs_pkg::sample_t'(MinVal);
    end else begin
      sat = shifted[W-1:0];
    end
  end

  // output register takes a request when empty or being drained
  assign ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ready_o) begin
      out_valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sample_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule
`default_nettype wire

// File: hdl/fir_decimator_hamming_sinc.sv
// fir_decimator_hamming_sinc: top level, transposed fir lowpass with decimation by four
// A result is registered in the first tap cell and then in the output register.
// Throughput: one input request per cycle while in_stall_o is low; one result per DECIM_FACTOR inputs.
// Pace is set by the row of tap cells, each with one multiplier and one add.
// Reset (asynchronous, active low) clears all partial sums, the phase and valids.
`timescale 1ns / 1ps
`default_nettype none
module fir_decimator_hamming_sinc (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [fdhs_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  input  wire logic                                 start_of_signal_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [fdhs_pkg::SAMPLE_WIDTH-1:0]  sample_out_o
);

  localparam int Taps = fdhs_pkg::TAP_COUNT;

  fdhs_pkg::acc_t  sums [Taps+1];
  fdhs_pkg::phase_t phase_q;
  fdhs_pkg::phase_t phase_d;
  fdhs_pkg::phase_t phase_base;
  logic [fdhs_pkg::PHASE_W:0] phase_inc;
  logic acc_valid_q;
  logic acc_valid_d;
  logic acc_ready;
  logic out_ready;
  logic accept;
  logic emit;

  // handshake: the first cell doubles as the accumulator stage
  assign acc_ready  = !acc_valid_q || out_ready;
  assign in_stall_o = !acc_ready;
  assign accept     = in_valid_i && acc_ready;

  // decimation phase
  always_comb begin
    phase_base = start_of_signal_i ? '0 : phase_q;
    emit       = (phase_base == '0);
    phase_inc  = {1'b0, phase_base} + 1'b1;
    if (phase_inc >= (fdhs_pkg::PHASE_W+1)'(fdhs_pkg::DECIM_FACTOR)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_inc[fdhs_pkg::PHASE_W-1:0];
    end
  end

  always_comb begin
    acc_valid_d = acc_valid_q;
    if (accept) begin
      acc_valid_d = emit;
    end else if (out_ready) begin
      acc_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      acc_valid_q <= 1'b0;
    end else begin
      acc_valid_q <= acc_valid_d;
      if (accept) begin
        phase_q <= phase_d;
      end
    end
  end

  // row of tap cells, last tap sees a zero neighbor
  assign sums[Taps] = '0;

  for (genvar k = 0; k < Taps; k++) begin : g_tap
    fdhs_cell #(
      .TAP_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .clear_i(start_of_signal_i),
      .x_i    (sample_in_i),
      .sum_i  (sums[k+1]),
      .sum_o  (sums[k])
    );
  end

  // rounding, saturation and output register
  fdhs_outstage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (acc_valid_q),
    .acc_i      (sums[0]),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_o   (sample_out_o)
  );

endmodule
`default_nettype wire
